// ===== rtl/ssd_pkg.sv =====
package ssd_pkg;

    localparam int NUM_DIGITS = 8;
    localparam int POS_W      = 3;
    localparam int CODE_W     = 5;
    localparam int FRAME_BITS = 16;
    localparam int BITNUM_W   = 4;

    localparam logic       REQ_REFRESH    = 1'b0;
    localparam logic       REQ_WRITE      = 1'b1;
    localparam logic [7:0] BLANK_SEGMENTS = 8'hFF;
    localparam logic [7:0] DOT_CLEAR_MASK = 8'h7F;
    localparam logic [7:0] SELECT_ALL_OFF = 8'hFF;

    typedef logic [FRAME_BITS-1:0] frame_t;

    // front -> queue push
    typedef struct packed {
        logic   push;
        frame_t frame;
    } frame_push_t;

    // queue -> back status and data
    typedef struct packed {
        logic   not_empty;
        frame_t frame;
    } frame_head_t;

    // active-low segments, bit 7 = dp
    function automatic logic [7:0] seg_lookup(input logic [CODE_W-1:0] code);
        logic [7:0] seg;
        unique case (code)
            5'd0:    seg = 8'hC0;
            5'd1:    seg = 8'hF9;
            5'd2:    seg = 8'hA4;
            5'd3:    seg = 8'hB0;
            5'd4:    seg = 8'h99;
            5'd5:    seg = 8'h92;
            5'd6:    seg = 8'h82;
            5'd7:    seg = 8'hF8;
            5'd8:    seg = 8'h80;
            5'd9:    seg = 8'h90;
            5'd10:   seg = 8'hBF;
            5'd11:   seg = 8'h88;
            5'd12:   seg = 8'h83;
            5'd13:   seg = 8'hC6;
            5'd14:   seg = 8'hA1;
            5'd15:   seg = 8'h86;
            5'd16:   seg = 8'h8E;
            default: seg = BLANK_SEGMENTS;
        endcase
        return seg;
    endfunction

endpackage

// ===== rtl/ssd_front.sv =====
module ssd_front (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic                         req_type,
    input  logic [ssd_pkg::POS_W-1:0]    write_position,
    input  logic [ssd_pkg::CODE_W-1:0]   write_digit,
    input  logic                         write_dot,
    input  logic                         q_full,
    output ssd_pkg::frame_push_t         push
);
    import ssd_pkg::*;

    logic [CODE_W-1:0] codes_reg [NUM_DIGITS];
    logic              dots_reg  [NUM_DIGITS];
    logic [POS_W-1:0]  scan_reg;
    logic [POS_W-1:0]  scan_next;
    logic              accept;
    logic              do_write;
    logic [7:0]        sel;
    logic [7:0]        seg;

    assign in_ready = !q_full;
    assign accept   = in_valid && in_ready;
    assign do_write = accept && (req_type == REQ_WRITE)
                      && ({1'b0, write_position} < (POS_W+1)'(NUM_DIGITS));

    always_comb
    begin
        sel = SELECT_ALL_OFF & ~(8'd1 << scan_reg);
        seg = seg_lookup(codes_reg[scan_reg]);
        if (dots_reg[scan_reg])
        begin
            seg = seg & DOT_CLEAR_MASK;
        end
        if ({1'b0, scan_reg} + 1'b1 >= (POS_W+1)'(NUM_DIGITS))
        begin
            scan_next = '0;
        end
        else
        begin
            scan_next = scan_reg + 1'b1;
        end
    end

    // frame is built at acceptance, so later writes cannot reach it
    assign push.push  = accept && (req_type == REQ_REFRESH);
    assign push.frame = {sel, seg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scan_reg <= '0;
            for (int p = 0; p < NUM_DIGITS; p++)
            begin
                codes_reg[p] <= CODE_W'(NUM_DIGITS - 1 - p);
                dots_reg[p]  <= 1'b0;
            end
        end
        else
        begin
            if (push.push)
            begin
                scan_reg <= scan_next;
            end
            if (do_write)
            begin
                codes_reg[write_position] <= write_digit;
                dots_reg[write_position]  <= write_dot;
            end
        end
    end

endmodule

// ===== rtl/ssd_queue.sv =====
module ssd_queue (
    input  logic                  clk,
    input  logic                  rst_n,
    input  ssd_pkg::frame_push_t  push,
    input  logic                  pop,
    output logic                  full,
    output ssd_pkg::frame_head_t  head
);
    import ssd_pkg::*;

    frame_t     mem_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg;
    logic [1:0] count_next;

    assign full           = (count_reg == 2'd2);
    assign head.not_empty = (count_reg != 2'd0);
    assign head.frame     = mem_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push.push && !pop)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (pop && !push.push)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            count_reg <= count_next;
            if (push.push)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push.push)
        begin
            mem_reg[wr_ptr_reg] <= push.frame;
        end
    end

endmodule

// ===== rtl/ssd_back.sv =====
module ssd_back (
    input  logic                         clk,
    input  logic                         rst_n,
    input  ssd_pkg::frame_head_t         head,
    output logic                         pop,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic                         serial_bit,
    output logic [ssd_pkg::BITNUM_W-1:0] bit_number,
    output logic                         latch_pulse
);
    import ssd_pkg::*;

    frame_t              shift_reg;
    logic [BITNUM_W-1:0] cnt_reg;
    logic                busy_reg;
    logic                last_bit;
    logic                out_take;

    assign last_bit    = (cnt_reg == BITNUM_W'(FRAME_BITS - 1));
    assign out_take    = busy_reg && out_ready;
    assign pop         = head.not_empty && (!busy_reg || (out_take && last_bit));
    assign out_valid   = busy_reg;
    assign serial_bit  = shift_reg[FRAME_BITS-1];
    assign bit_number  = cnt_reg;
    assign latch_pulse = last_bit;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            if (pop)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (out_take)
            begin
                if (last_bit)
                begin
                    busy_reg <= 1'b0;
                end
                cnt_reg <= cnt_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            shift_reg <= head.frame;
        end
        else if (out_take)
        begin
            shift_reg <= {shift_reg[FRAME_BITS-2:0], 1'b0};
        end
    end

endmodule

// ===== rtl/seven_segment_scan_shift_driver.sv =====
// Eight-digit multiplexed seven-segment driver for two chained serial shift
// registers. A write word (req_type 1) updates one position's symbol code and
// dot at once and gives no output. A refresh word (req_type 0) captures the
// current position's frame into a two-deep frame queue and advances the scan
// position; the serializer then presents 16 bit words, select byte first, MSB
// first, with latch_pulse on bit 15. Each frame occupies the serial output for
// 16 accepted output words, one per cycle when out_ready stays high. Writes
// are taken every cycle unless the frame queue is full.
module seven_segment_scan_shift_driver (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic                         req_type,
    input  logic [ssd_pkg::POS_W-1:0]    write_position,
    input  logic [ssd_pkg::CODE_W-1:0]   write_digit,
    input  logic                         write_dot,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic                         serial_bit,
    output logic [ssd_pkg::BITNUM_W-1:0] bit_number,
    output logic                         latch_pulse
);
    import ssd_pkg::*;

    frame_push_t push;
    frame_head_t head;
    logic        q_full;
    logic        pop;

    ssd_front u_front (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .req_type       (req_type),
        .write_position (write_position),
        .write_digit    (write_digit),
        .write_dot      (write_dot),
        .q_full         (q_full),
        .push           (push)
    );

    ssd_queue u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .pop   (pop),
        .full  (q_full),
        .head  (head)
    );

    ssd_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .head        (head),
        .pop         (pop),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .serial_bit  (serial_bit),
        .bit_number  (bit_number),
        .latch_pulse (latch_pulse)
    );

endmodule

// ===== tb/ssd_frame_checker.sv =====
module ssd_frame_checker (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    input  logic                         in_ready,
    input  logic                         req_type,
    input  logic [ssd_pkg::POS_W-1:0]    write_position,
    input  logic [ssd_pkg::CODE_W-1:0]   write_digit,
    input  logic                         write_dot,
    input  logic                         out_valid,
    input  logic                         out_ready,
    input  logic                         serial_bit,
    input  logic [ssd_pkg::BITNUM_W-1:0] bit_number,
    input  logic                         latch_pulse,
    output int                           errors,
    output int                           pending
);
    import ssd_pkg::*;

    typedef struct packed {
        logic                data;
        logic [BITNUM_W-1:0] index;
        logic                latch;
    } shift_bit_t;

    // active-low glyphs, bit 7 is the dot
    localparam logic [7:0] GLYPHS [17] = '{
        8'hC0, 8'hF9, 8'hA4, 8'hB0, 8'h99, 8'h92, 8'h82, 8'hF8,
        8'h80, 8'h90, 8'hBF, 8'h88, 8'h83, 8'hC6, 8'hA1, 8'h86,
        8'h8E
    };

    logic [CODE_W-1:0] shadow_codes [NUM_DIGITS];
    logic              shadow_dots  [NUM_DIGITS];
    logic [POS_W-1:0]  shadow_scan;
    shift_bit_t        bits_due [$];

    function automatic logic [7:0] glyph_of(input logic [CODE_W-1:0] code,
                                            input logic dot);
        logic [7:0] seg;
        seg = (code < 17) ? GLYPHS[code] : BLANK_SEGMENTS;
        if (dot)
            seg = seg & DOT_CLEAR_MASK;
        return seg;
    endfunction

    task automatic queue_frame();
        logic [7:0]      sel;
        logic [15:0]     frame;
        shift_bit_t      b;
        sel = SELECT_ALL_OFF;
        sel[shadow_scan] = 1'b0;
        frame = {sel, glyph_of(shadow_codes[shadow_scan], shadow_dots[shadow_scan])};
        for (int k = 0; k < FRAME_BITS; k++)
        begin
            b.data  = frame[FRAME_BITS-1-k];
            b.index = k[BITNUM_W-1:0];
            b.latch = (k == FRAME_BITS - 1);
            bits_due.push_back(b);
        end
        if (int'(shadow_scan) + 1 >= NUM_DIGITS)
            shadow_scan = '0;
        else
            shadow_scan = shadow_scan + 1'b1;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        shift_bit_t want;
        if (!rst_n)
        begin
            for (int p = 0; p < NUM_DIGITS; p++)
            begin
                shadow_codes[p] = CODE_W'(7 - p);
                shadow_dots[p]  = 1'b0;
            end
            shadow_scan = '0;
            bits_due.delete();
            errors  = 0;
            pending = 0;
        end
        else
        begin
            if (in_valid && in_ready)
            begin
                if (req_type == REQ_WRITE)
                begin
                    if (int'(write_position) < NUM_DIGITS)
                    begin
                        shadow_codes[write_position] = write_digit;
                        shadow_dots[write_position]  = write_dot;
                    end
                end
                else
                    queue_frame();
            end
            if (out_valid && out_ready)
            begin
                if (bits_due.size() == 0)
                begin
                    $error("output word with no expected bit pending");
                    errors++;
                end
                else
                begin
                    want = bits_due.pop_front();
                    if (serial_bit !== want.data)
                    begin
                        $error("serial_bit expected %0d actual %0d", want.data, serial_bit);
                        errors++;
                    end
                    if (bit_number !== want.index)
                    begin
                        $error("bit_number expected %0d actual %0d", want.index, bit_number);
                        errors++;
                    end
                    if (latch_pulse !== want.latch)
                    begin
                        $error("latch_pulse expected %0d actual %0d",
                               want.latch, latch_pulse);
                        errors++;
                    end
                end
            end
            pending = bits_due.size();
        end
    end

endmodule

// ===== tb/tb_seven_segment_scan_shift_driver.sv =====
module tb_seven_segment_scan_shift_driver;
    import ssd_pkg::*;

    localparam int STALL_LIMIT   = 2000;
    localparam int RANDOM_WORDS  = 260;
    localparam int DRAIN_CYCLES  = 40;

    logic                clk            = 1'b0;
    logic                rst_n          = 1'b0;
    logic                in_valid       = 1'b0;
    logic                in_ready;
    logic                req_type       = REQ_REFRESH;
    logic [POS_W-1:0]    write_position = '0;
    logic [CODE_W-1:0]   write_digit    = '0;
    logic                write_dot      = 1'b0;
    logic                out_valid;
    logic                out_ready      = 1'b0;
    logic                serial_bit;
    logic [BITNUM_W-1:0] bit_number;
    logic                latch_pulse;

    int errors;
    int pending;
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int quiet_cycles   = 0;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    seven_segment_scan_shift_driver dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .req_type       (req_type),
        .write_position (write_position),
        .write_digit    (write_digit),
        .write_dot      (write_dot),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .serial_bit     (serial_bit),
        .bit_number     (bit_number),
        .latch_pulse    (latch_pulse)
    );

    ssd_frame_checker checker_i (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .req_type       (req_type),
        .write_position (write_position),
        .write_digit    (write_digit),
        .write_dot      (write_dot),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .serial_bit     (serial_bit),
        .bit_number     (bit_number),
        .latch_pulse    (latch_pulse),
        .errors         (errors),
        .pending        (pending)
    );

    always @(posedge clk)
        out_ready <= ($urandom_range(99) >= recv_stall_pct);

    // ends the run if the channels go quiet for too long
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("tb_seven_segment_scan_shift_driver failed");
            $finish;
        end
    end

    task automatic send_word(input logic req, input logic [POS_W-1:0] pos,
                             input logic [CODE_W-1:0] code, input logic dot);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid       <= 1'b1;
        req_type       <= req;
        write_position <= pos;
        write_digit    <= code;
        write_dot      <= dot;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
    endtask

    task automatic send_random_word();
        logic [CODE_W-1:0] code;
        if ($urandom_range(9) < 8)
            code = CODE_W'($urandom_range(16));
        else
            code = CODE_W'($urandom_range(31, 17));
        send_word($urandom_range(1) ? REQ_WRITE : REQ_REFRESH,
                  POS_W'($urandom_range(7)), code, 1'($urandom_range(1)));
    endtask

    initial
    begin
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset contents, full scan and wrap
        for (int i = 0; i < NUM_DIGITS; i++)
            send_word(REQ_REFRESH, '0, '0, 1'b0);
        // last glyph with dot, blank codes, dash, first glyph
        send_word(REQ_WRITE, 3'd0, 5'd16, 1'b1);
        send_word(REQ_WRITE, 3'd7, 5'd31, 1'b1);
        send_word(REQ_WRITE, 3'd3, 5'd17, 1'b0);
        send_word(REQ_WRITE, 3'd1, 5'd10, 1'b0);
        send_word(REQ_WRITE, 3'd2, 5'd0,  1'b1);
        send_word(REQ_WRITE, 3'd4, 5'd15, 1'b0);
        send_word(REQ_WRITE, 3'd5, 5'd8,  1'b1);
        send_word(REQ_WRITE, 3'd6, 5'd9,  1'b0);
        for (int i = 0; i < NUM_DIGITS; i++)
            send_word(REQ_REFRESH, 3'd7, 5'd31, 1'b1);

        for (int ph = 0; ph < 4; ph++)
        begin
            case (ph)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 67; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 67; end
                default: begin send_idle_pct = 10; recv_stall_pct = 10; end
            endcase
            for (int i = 0; i < RANDOM_WORDS / 4; i++)
                send_random_word();
        end
        in_valid <= 1'b0;

        while (pending != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (errors == 0 && pending == 0)
            $display("tb_seven_segment_scan_shift_driver passed");
        else
            $display("tb_seven_segment_scan_shift_driver failed");
        $finish;
    end

endmodule

// ===== files.f =====
rtl/ssd_pkg.sv
rtl/ssd_front.sv
rtl/ssd_queue.sv
rtl/ssd_back.sv
rtl/seven_segment_scan_shift_driver.sv
tb/ssd_frame_checker.sv
tb/tb_seven_segment_scan_shift_driver.sv
